// File: src/eat_pkg.sv
// Package with the shared types, codes and constants of the event-action table.
`timescale 1ns / 1ps
package eat_pkg;
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SEVERITY_QUEUES_DEF = 4;
    localparam int SLOT_OUT_W = 4;

    typedef enum logic [2:0] {
        CMD_DEFINE  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_EVENT   = 3'd4,
        CMD_EXTRACT = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_UNKNOWN   = 4'd1,
        ST_FULL      = 4'd2,
        ST_ENABLED   = 4'd3,
        ST_REJECTED  = 4'd4,
        ST_UNDEFINED = 4'd5,
        ST_IGNORED   = 4'd6,
        ST_QFULL     = 4'd7,
        ST_EMPTY     = 4'd8,
        ST_QUEUED    = 4'd9,
        ST_EXTRACTED = 4'd10
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_EXEC,
        S_QREAD,
        S_DONE
    } t_state;
endpackage

// File: src/eat_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module eat_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/event_action_table_priority_queue_core.sv
// Top level of the event-action table with per-severity pending queues.
`timescale 1ns / 1ps
// A command is taken when i_start is high and o_busy is low; its single result
// shows on o_status, o_slot_index and o_all_queues_empty for exactly one cycle
// with o_done high, and the receiver cannot stall it. A command passes through
// the states S_SCAN, S_SCAN_LAST, S_EXEC and S_DONE from transfer to result,
// and an extract that finds a pending entry also passes through S_QREAD for
// the queue read. The next command can be taken at the edge that ends the
// result cycle. The slot table lives in one RAM with one read port, so the block
// reads every slot once, in order, to find the lowest match and the lowest
// free slot, then writes back the one slot it changes. The pending queues
// share a second RAM, indexed by queue and position; head and count of each
// queue sit in flip-flops. The slot RAM needs no clearing pass: a valid bit per
// slot, cleared by reset, makes an unwritten slot read as free and disabled.
module event_action_table_priority_queue_core
    import eat_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int SEVERITY_QUEUES = SEVERITY_QUEUES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_event_id,
    input  logic [2:0]  i_rid_class,
    input  logic        i_rid_enabled,
    input  logic        i_packet_accepted,
    output logic        o_busy,
    output logic        o_done,
    output logic [3:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic        o_all_queues_empty
);
    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int VW = (SEVERITY_QUEUES > 1) ? $clog2(SEVERITY_QUEUES) : 1;
    localparam int PW = VW + QW;
    localparam int PD = 1 << PW;

    t_state r_state, n_state;

    // Captured command.
    logic [2:0]  r_cmd;
    logic [15:0] r_id;
    logic [2:0]  r_cls;
    logic        r_rid_on, r_acc;

    // Scan bookkeeping.
    logic [SW-1:0] r_addr, n_addr;
    logic [SW-1:0] r_rd_slot;
    logic          r_found, n_found;
    logic [SW-1:0] r_match, n_match;
    logic          r_mact, n_mact;
    logic          r_free_ok, n_free_ok;
    logic [SW-1:0] r_free, n_free;

    logic [TABLE_SLOTS-1:0] r_valid;
    logic [16:0]            slot_rdata;
    logic                   slot_we;
    logic [SW-1:0]          slot_waddr;
    logic [16:0]            slot_wdata;
    logic [SW-1:0]          slot_raddr;
    logic [15:0]            rd_ev;
    logic                   rd_act;

    logic [QW-1:0] r_head  [SEVERITY_QUEUES];
    logic [CW-1:0] r_count [SEVERITY_QUEUES];
    logic [VW-1:0] r_xq;

    logic          pq_we;
    logic [PW-1:0] pq_waddr, pq_raddr;
    logic [3:0]    pq_wdata, pq_rdata;
    logic [SW-1:0] pq_rslot;

    t_status       r_st;
    logic [SW-1:0] r_slot;
    logic          r_done;
    t_status       n_st;
    logic [SW-1:0] n_slot;

    logic [VW-1:0] ev_q;
    logic [QW:0]   tail_sum;
    logic [QW-1:0] tail;
    logic          any_pend;
    logic [VW-1:0] top_q;
    logic          unknown;

    eat_ram #(.WIDTH(17), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );

    // The pending store keeps four bits of each slot index, as on the output.
    eat_ram #(.WIDTH(4), .DEPTH(PD)) u_pend_ram (
        .i_clk(i_clk), .i_we(pq_we), .i_waddr(pq_waddr), .i_wdata(pq_wdata),
        .i_raddr(pq_raddr), .o_rdata(pq_rdata)
    );

    assign slot_raddr = r_addr;
    assign rd_ev  = r_valid[r_rd_slot] ? slot_rdata[15:0] : 16'd0;
    assign rd_act = r_valid[r_rd_slot] ? slot_rdata[16] : 1'b0;
    assign unknown = (r_cls == 3'd0) || (r_id == 16'd0);
    assign pq_rslot = SW'(pq_rdata);

    always_comb begin
        if (r_cls == 3'd0 || ({29'd0, r_cls} - 32'd1) > 32'(SEVERITY_QUEUES - 1)) begin
            ev_q = VW'(SEVERITY_QUEUES - 1);
        end else begin
            ev_q = VW'(r_cls - 3'd1);
        end
        tail_sum = {1'b0, r_head[ev_q]} + (QW + 1)'(r_count[ev_q]);
        tail = (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
               QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    end

    // Highest non-empty queue wins.
    always_comb begin
        any_pend = 1'b0;
        top_q = '0;
        for (int q = 0; q < SEVERITY_QUEUES; q++) begin
            if (r_count[q] != '0) begin
                any_pend = 1'b1;
                top_q = VW'(q);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_start) n_state = S_SCAN;
            S_SCAN:      if (r_addr == SW'(TABLE_SLOTS - 1)) n_state = S_SCAN_LAST;
            S_SCAN_LAST: n_state = S_EXEC;
            S_EXEC:      n_state = (r_cmd == CMD_EXTRACT && any_pend) ? S_QREAD : S_DONE;
            S_QREAD:     n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Scan: one slot read issued per cycle, evaluated the cycle after.
    always_comb begin
        n_addr = r_addr;
        n_found = r_found;
        n_match = r_match;
        n_mact = r_mact;
        n_free_ok = r_free_ok;
        n_free = r_free;
        if (r_state == S_IDLE) begin
            n_addr = '0;
            n_found = 1'b0;
            n_free_ok = 1'b0;
            n_mact = 1'b0;
            n_match = '0;
            n_free = '0;
        end
        if (r_state == S_SCAN && r_addr != SW'(TABLE_SLOTS - 1)) begin
            n_addr = r_addr + SW'(1);
        end
        if ((r_state == S_SCAN && r_addr != '0) || r_state == S_SCAN_LAST) begin
            if (!r_found && r_id != 16'd0 && rd_ev == r_id) begin
                n_found = 1'b1;
                n_match = r_rd_slot;
                n_mact = rd_act;
            end
            if (!r_free_ok && rd_ev == 16'd0) begin
                n_free_ok = 1'b1;
                n_free = r_rd_slot;
            end
        end
    end

    // Execution outputs: slot table and pending queue writes.
    always_comb begin
        slot_we = 1'b0;
        slot_waddr = r_match;
        slot_wdata = {1'b0, r_id};
        pq_we = 1'b0;
        pq_waddr = {ev_q, tail};
        pq_wdata = 4'(r_match);
        pq_raddr = {top_q, r_head[top_q]};
        if (r_state == S_EXEC && !unknown) begin
            unique case (r_cmd)
                CMD_DEFINE: begin
                    if (n_st == ST_OK) begin
                        slot_we = 1'b1;
                        slot_waddr = r_found ? r_match : r_free;
                    end
                end
                CMD_DELETE: begin
                    if (n_st == ST_OK) begin
                        slot_we = 1'b1;
                        slot_wdata = '0;
                    end
                end
                CMD_ENABLE, CMD_DISABLE: begin
                    if (r_found) begin
                        slot_we = 1'b1;
                        slot_wdata = {(r_cmd == CMD_ENABLE), r_id};
                    end
                end
                default: begin end
            endcase
        end
        if (r_state == S_EXEC && r_cmd == CMD_EVENT && n_st == ST_QUEUED) begin
            pq_we = 1'b1;
        end
    end

    always_comb begin
        n_st = r_st;
        n_slot = r_slot;
        if (r_state == S_EXEC) begin
            n_st = ST_IGNORED;
            n_slot = '0;
            unique case (r_cmd)
                CMD_DEFINE: begin
                    if (unknown) begin
                        n_st = ST_UNKNOWN;
                    end else if (r_found && r_mact) begin
                        n_st = ST_ENABLED;
                        n_slot = r_match;
                    end else if (!r_found && !r_free_ok) begin
                        n_st = ST_FULL;
                    end else begin
                        n_slot = r_found ? r_match : r_free;
                        n_st = r_acc ? ST_OK : ST_REJECTED;
                    end
                end
                CMD_DELETE, CMD_ENABLE, CMD_DISABLE: begin
                    if (unknown) begin
                        n_st = ST_UNKNOWN;
                    end else if (!r_found) begin
                        n_st = ST_UNDEFINED;
                    end else begin
                        n_slot = r_match;
                        n_st = (r_cmd == CMD_DELETE && r_mact) ? ST_ENABLED : ST_OK;
                    end
                end
                CMD_EVENT: begin
                    if (r_found) n_slot = r_match;
                    if (r_rid_on && r_cls != 3'd0 && r_found && r_mact) begin
                        n_st = (r_count[ev_q] >= CW'(QUEUE_DEPTH)) ? ST_QFULL : ST_QUEUED;
                    end
                end
                CMD_EXTRACT: n_st = any_pend ? ST_EXTRACTED : ST_EMPTY;
                default: n_st = ST_IGNORED;
            endcase
        end else if (r_state == S_QREAD) begin
            n_slot = pq_rslot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd <= i_cmd;
            r_id <= i_event_id;
            r_cls <= i_rid_class;
            r_rid_on <= i_rid_enabled;
            r_acc <= i_packet_accepted;
        end
        r_rd_slot <= r_addr;
        r_found <= n_found;
        r_match <= n_match;
        r_mact <= n_mact;
        r_free_ok <= n_free_ok;
        r_free <= n_free;
        r_st <= n_st;
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr <= '0;
            r_valid <= '0;
            r_done <= 1'b0;
            r_xq <= '0;
            for (int q = 0; q < SEVERITY_QUEUES; q++) begin
                r_head[q] <= '0;
                r_count[q] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_done <= (r_state == S_DONE);
            if (slot_we) r_valid[slot_waddr] <= 1'b1;
            if (r_state == S_EXEC && r_cmd == CMD_EVENT && n_st == ST_QUEUED) begin
                r_count[ev_q] <= r_count[ev_q] + CW'(1);
            end
            if (r_state == S_EXEC && r_cmd == CMD_EXTRACT && any_pend) begin
                r_xq <= top_q;
            end
            if (r_state == S_QREAD) begin
                r_count[r_xq] <= r_count[r_xq] - CW'(1);
                r_head[r_xq] <= (r_head[r_xq] == QW'(QUEUE_DEPTH - 1)) ?
                                '0 : r_head[r_xq] + QW'(1);
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_status = r_st;
    assign o_slot_index = 4'(r_slot);
    always_comb begin
        o_all_queues_empty = 1'b1;
        for (int q = 0; q < SEVERITY_QUEUES; q++) begin
            if (r_count[q] != '0) o_all_queues_empty = 1'b0;
        end
    end
endmodule

// File: tb/tb_event_action_table_priority_queue_core.sv
// Self-checking testbench for the event-action table with severity pending queues.
`timescale 1ns / 1ps
module tb_event_action_table_priority_queue_core;
    import eat_pkg::*;

    localparam int NSLOT = TABLE_SLOTS_DEF;
    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam int NQ = SEVERITY_QUEUES_DEF;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] slot;
        logic       empty;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [2:0]  i_cmd;
    logic [15:0] i_event_id;
    logic [2:0]  i_rid_class;
    logic        i_rid_enabled;
    logic        i_packet_accepted;
    logic        o_busy;
    logic        o_done;
    logic [3:0]  o_status;
    logic [3:0]  o_slot_index;
    logic        o_all_queues_empty;

    event_action_table_priority_queue_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .i_event_id(i_event_id), .i_rid_class(i_rid_class),
        .i_rid_enabled(i_rid_enabled), .i_packet_accepted(i_packet_accepted),
        .o_busy(o_busy), .o_done(o_done), .o_status(o_status),
        .o_slot_index(o_slot_index), .o_all_queues_empty(o_all_queues_empty)
    );

    // Shadow copy of the table and the pending queues.
    logic [15:0] tbl_id [NSLOT];
    logic        tbl_on [NSLOT];
    logic [3:0]  pend [NQ][QDEPTH];
    int          qhead [NQ];
    int          qcnt [NQ];

    t_answer answers_due[$];
    int      n_errors;
    int      n_sent;
    int      n_checked;
    int      n_queued;
    int      n_extracted;
    int      idle_cycles;
    logic    burst_on;

    // Recently used IDs, so that random commands hit defined slots often.
    logic [15:0] id_pool [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int lookup(input logic [15:0] id);
        if (id == 16'd0) return -1;
        for (int k = 0; k < NSLOT; k++) if (tbl_id[k] == id) return k;
        return -1;
    endfunction

    function automatic logic none_pending();
        for (int q = 0; q < NQ; q++) if (qcnt[q] != 0) return 1'b0;
        return 1'b1;
    endfunction

    // Applies one command to the shadow state and returns the answer it must give.
    function automatic t_answer apply_command(input logic [2:0] cmd, input logic [15:0] id,
                                              input logic [2:0] cls, input logic rid_on,
                                              input logic accepted);
        t_answer a;
        int m;
        int q;
        a.status = ST_IGNORED;
        a.slot = 4'd0;
        if (cmd <= CMD_DISABLE && (cls == 3'd0 || id == 16'd0)) begin
            a.status = ST_UNKNOWN;
        end else if (cmd == CMD_DEFINE) begin
            m = lookup(id);
            if (m >= 0 && tbl_on[m]) begin
                a.status = ST_ENABLED;
                a.slot = m[3:0];
            end else begin
                if (m < 0) begin
                    for (int k = NSLOT - 1; k >= 0; k--) if (tbl_id[k] == 16'd0) m = k;
                end
                if (m < 0) begin
                    a.status = ST_FULL;
                end else begin
                    a.slot = m[3:0];
                    if (!accepted) begin
                        a.status = ST_REJECTED;
                    end else begin
                        tbl_id[m] = id;
                        tbl_on[m] = 1'b0;
                        a.status = ST_OK;
                    end
                end
            end
        end else if (cmd <= CMD_DISABLE) begin
            m = lookup(id);
            if (m < 0) begin
                a.status = ST_UNDEFINED;
            end else begin
                a.slot = m[3:0];
                if (cmd == CMD_DELETE) begin
                    if (tbl_on[m]) begin
                        a.status = ST_ENABLED;
                    end else begin
                        tbl_id[m] = 16'd0;
                        a.status = ST_OK;
                    end
                end else begin
                    tbl_on[m] = (cmd == CMD_ENABLE);
                    a.status = ST_OK;
                end
            end
        end else if (cmd == CMD_EVENT) begin
            m = lookup(id);
            if (m >= 0) a.slot = m[3:0];
            if (rid_on && cls != 3'd0 && m >= 0 && tbl_on[m]) begin
                q = (int'(cls) - 1 > NQ - 1) ? NQ - 1 : int'(cls) - 1;
                if (qcnt[q] >= QDEPTH) begin
                    a.status = ST_QFULL;
                end else begin
                    pend[q][(qhead[q] + qcnt[q]) % QDEPTH] = m[3:0];
                    qcnt[q]++;
                    a.status = ST_QUEUED;
                end
            end
        end else if (cmd == CMD_EXTRACT) begin
            a.status = ST_EMPTY;
            for (int s = NQ - 1; s >= 0; s--) begin
                if (qcnt[s] != 0 && a.status == ST_EMPTY) begin
                    a.slot = pend[s][qhead[s]];
                    qhead[s] = (qhead[s] + 1) % QDEPTH;
                    qcnt[s]--;
                    a.status = ST_EXTRACTED;
                end
            end
        end
        a.empty = none_pending();
        return a;
    endfunction

    // Sends one command: waits for a free block, holds start for one transfer,
    // and records the expected answer at the accepting edge.
    task automatic send_command(input logic [2:0] cmd, input logic [15:0] id,
                                input logic [2:0] cls, input logic rid_on,
                                input logic accepted);
        t_answer a;
        // Sender gaps come in bursts: a new burst decides whether to pause.
        if (!burst_on) begin
            repeat ($urandom_range(0, 30)) @(negedge i_clk);
            burst_on = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            burst_on = 1'b0;
        end
        i_cmd = cmd;
        i_event_id = id;
        i_rid_class = cls;
        i_rid_enabled = rid_on;
        i_packet_accepted = accepted;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        a = apply_command(cmd, id, cls, rid_on, accepted);
        if (cmd == CMD_EVENT && a.status == ST_QUEUED) n_queued++;
        if (cmd == CMD_EXTRACT && a.status == ST_EXTRACTED) n_extracted++;
        answers_due.push_back(a);
        n_sent++;
        @(negedge i_clk);
        i_start = 1'b0;
        i_cmd = 3'($urandom_range(0, 7));
        i_event_id = 16'($urandom);
    endtask

    // Result checker: every strobe must match the oldest expected answer.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d slot %0d empty %0b",
                         $time, o_status, o_slot_index, o_all_queues_empty);
                n_errors++;
            end else begin
                want = answers_due.pop_front();
                n_checked++;
                if (o_status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                if (o_slot_index !== want.slot)
                    $display("%0t: slot_index expected %0d actual %0d", $time, want.slot,
                             o_slot_index);
                if (o_all_queues_empty !== want.empty)
                    $display("%0t: all_queues_empty expected %0b actual %0b", $time,
                             want.empty, o_all_queues_empty);
                if (o_status !== want.status || o_slot_index !== want.slot ||
                    o_all_queues_empty !== want.empty)
                    n_errors++;
            end
        end
    end

    // Watchdog on cycles without any transfer or result.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL event_action_table_priority_queue_core");
            $finish;
        end
    end

    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return id_pool[$urandom_range(0, 7)];
        if (r == 7) return 16'd0;
        if (r == 8) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Directed checks on the edges of the fields and every status code but ST_FULL and ST_QFULL.
    task automatic test_directed();
        send_command(CMD_EXTRACT, 16'd0, 3'd0, 1'b0, 1'b0);          // empty
        send_command(CMD_DEFINE, 16'd0, 3'd4, 1'b1, 1'b1);           // id zero
        send_command(CMD_DEFINE, 16'hFFFF, 3'd0, 1'b1, 1'b1);        // class zero
        send_command(CMD_DEFINE, 16'hFFFF, 3'd4, 1'b0, 1'b0);        // rejected
        send_command(CMD_DEFINE, 16'hFFFF, 3'd4, 1'b0, 1'b1);
        send_command(CMD_DEFINE, 16'h0001, 3'd7, 1'b0, 1'b1);
        send_command(CMD_DEFINE, 16'hFFFF, 3'd1, 1'b0, 1'b1);        // reuse disabled
        send_command(CMD_ENABLE, 16'hFFFF, 3'd1, 1'b0, 1'b0);
        send_command(CMD_DEFINE, 16'hFFFF, 3'd1, 1'b0, 1'b1);        // slot enabled
        send_command(CMD_DELETE, 16'hFFFF, 3'd2, 1'b0, 1'b0);        // slot enabled
        send_command(CMD_DELETE, 16'h1234, 3'd2, 1'b0, 1'b0);        // not defined
        send_command(CMD_EVENT, 16'hFFFF, 3'd1, 1'b0, 1'b0);         // report off
        send_command(CMD_EVENT, 16'hFFFF, 3'd0, 1'b1, 1'b0);         // class zero
        send_command(CMD_EVENT, 16'h0001, 3'd4, 1'b1, 1'b0);         // slot disabled
        send_command(CMD_EVENT, 16'hFFFF, 3'd7, 1'b1, 1'b0);         // saturated class
        send_command(CMD_EVENT, 16'hFFFF, 3'd1, 1'b1, 1'b0);
        send_command(CMD_EVENT, 16'hFFFF, 3'd2, 1'b1, 1'b1);
        send_command(3'd6, 16'hFFFF, 3'd1, 1'b1, 1'b1);              // unused command
        send_command(3'd7, 16'h5555, 3'd5, 1'b1, 1'b1);
        send_command(CMD_EXTRACT, 16'hAAAA, 3'd3, 1'b1, 1'b1);
        send_command(CMD_EXTRACT, 16'h0, 3'd0, 1'b0, 1'b0);
        send_command(CMD_DISABLE, 16'hFFFF, 3'd3, 1'b0, 1'b0);
        send_command(CMD_DISABLE, 16'hFFFF, 3'd3, 1'b0, 1'b0);       // already off
        send_command(CMD_DELETE, 16'hFFFF, 3'd3, 1'b0, 1'b0);
    endtask

    // Fills the table past full, then one queue past its depth, then drains.
    task automatic test_limits();
        for (int k = 0; k <= NSLOT; k++)
            send_command(CMD_DEFINE, 16'(16'h0100 + k), 3'd2, 1'b0, 1'b1);
        send_command(CMD_ENABLE, 16'h0103, 3'd2, 1'b0, 1'b0);
        for (int k = 0; k <= QDEPTH + 1; k++)
            send_command(CMD_EVENT, 16'h0103, 3'd3, 1'b1, 1'b0);
        for (int k = 0; k <= QDEPTH + 1; k++)
            send_command(CMD_EXTRACT, 16'd0, 3'd0, 1'b0, 1'b0);
        send_command(CMD_DISABLE, 16'h0103, 3'd2, 1'b0, 1'b0);
        for (int k = 0; k < NSLOT; k++)
            send_command(CMD_DELETE, 16'(16'h0100 + k), 3'd2, 1'b0, 1'b0);
    endtask

    // Random traffic biased toward defined, enabled slots and queue activity.
    task automatic test_random(input int count);
        logic [2:0] cmd;
        int r;
        for (int k = 0; k < 8; k++) id_pool[k] = 16'(1 + $urandom_range(0, 16'hFFFE));
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 15) cmd = CMD_DEFINE;
            else if (r < 22) cmd = CMD_DELETE;
            else if (r < 35) cmd = CMD_ENABLE;
            else if (r < 40) cmd = CMD_DISABLE;
            else if (r < 72) cmd = CMD_EVENT;
            else if (r < 97) cmd = CMD_EXTRACT;
            else cmd = 3'($urandom_range(6, 7));
            if ($urandom_range(0, 199) == 0)
                id_pool[$urandom_range(0, 7)] = 16'(1 + $urandom_range(0, 16'hFFFE));
            send_command(cmd, pick_id(), ($urandom_range(0, 9) == 0) ? 3'd0
                         : 3'($urandom_range(1, 7)), $urandom_range(0, 7) != 0,
                         $urandom_range(0, 5) != 0);
        end
    endtask

    initial begin
        int wait_cycles;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_queued = 0;
        n_extracted = 0;
        idle_cycles = 0;
        burst_on = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = CMD_DEFINE;
        i_event_id = 16'd0;
        i_rid_class = 3'd0;
        i_rid_enabled = 1'b0;
        i_packet_accepted = 1'b0;
        for (int k = 0; k < NSLOT; k++) begin
            tbl_id[k] = 16'd0;
            tbl_on[k] = 1'b0;
        end
        for (int q = 0; q < NQ; q++) begin
            qhead[q] = 0;
            qcnt[q] = 0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_limits();
        test_random(1350);

        // Drain: wait for the outstanding answer, then check that no answer is left.
        wait_cycles = 0;
        while (answers_due.size() != 0 && wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (NSLOT + 10) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, answers_due.size());
            n_errors++;
        end

        $display("Ran %0d commands, checked %0d results; %0d events queued, %0d extracted.",
                 n_sent, n_checked, n_queued, n_extracted);
        if (n_errors == 0) begin
            $display("PASS event_action_table_priority_queue_core");
        end else begin
            $display("FAIL event_action_table_priority_queue_core");
        end
        $finish;
    end
endmodule

// File: files.f
src/eat_pkg.sv
src/eat_ram.sv
src/event_action_table_priority_queue_core.sv
tb/tb_event_action_table_priority_queue_core.sv
